FILE: rtl/core/m3i_pkg.sv
// Shared constants for the 3x3 matrix inverse pipeline.
package m3i_pkg;

	localparam int ELEM_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;
	localparam int NUM_ELEM       = 9;
	localparam int NUM_PROD       = 18;
	localparam int DET_MIN_WIDTH  = 31;
	localparam logic [DET_MIN_WIDTH-1:0] DET_MIN_RESET = DET_MIN_WIDTH'(1);

	// Cofactor k = a[PA[2k]]*a[PB[2k]] - a[PA[2k+1]]*a[PB[2k+1]]
	localparam int PA [NUM_PROD] = '{4, 5, 7, 8, 1, 2, 5, 3, 8, 6, 2, 0, 3, 4, 6, 7, 0, 1};
	localparam int PB [NUM_PROD] = '{8, 7, 2, 1, 5, 4, 6, 8, 0, 2, 3, 5, 7, 6, 1, 0, 4, 3};

	// Cofactors of row 0 used for the determinant
	localparam int DET_COF [3] = '{0, 3, 6};

endpackage

FILE: rtl/core/matrix3x3_inverse.sv
// Pipelined 3x3 matrix inverse: the adjugate scaled by the reciprocal of the determinant.
// Takes one matrix per cycle; the depth is set by the restoring divider, which resolves one quotient
// bit of all nine elements per stage. Each element is round(cofactor * 2^(2*FRAC_BITS) / det)
// with ties away from zero, clipped to the signed ELEM_WIDTH range with saturated raised. When
// |det| is at or below det_min (unsigned Q15.16), singular is raised and all elements read zero. The
// pipeline stalls as a whole when the output item is not taken.
module matrix3x3_inverse #(
	parameter int ELEM_WIDTH = m3i_pkg::ELEM_WIDTH_DEF,
	parameter int FRAC_BITS  = m3i_pkg::FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [m3i_pkg::DET_MIN_WIDTH-1:0] cfg_wdata,
	input  logic in_valid,
	output logic in_ready,
	input  logic signed [ELEM_WIDTH-1:0] a00,
	input  logic signed [ELEM_WIDTH-1:0] a01,
	input  logic signed [ELEM_WIDTH-1:0] a02,
	input  logic signed [ELEM_WIDTH-1:0] a10,
	input  logic signed [ELEM_WIDTH-1:0] a11,
	input  logic signed [ELEM_WIDTH-1:0] a12,
	input  logic signed [ELEM_WIDTH-1:0] a20,
	input  logic signed [ELEM_WIDTH-1:0] a21,
	input  logic signed [ELEM_WIDTH-1:0] a22,
	output logic out_valid,
	input  logic out_ready,
	output logic signed [ELEM_WIDTH-1:0] b00,
	output logic signed [ELEM_WIDTH-1:0] b01,
	output logic signed [ELEM_WIDTH-1:0] b02,
	output logic signed [ELEM_WIDTH-1:0] b10,
	output logic signed [ELEM_WIDTH-1:0] b11,
	output logic signed [ELEM_WIDTH-1:0] b12,
	output logic signed [ELEM_WIDTH-1:0] b20,
	output logic signed [ELEM_WIDTH-1:0] b21,
	output logic signed [ELEM_WIDTH-1:0] b22,
	output logic singular,
	output logic saturated
);
	import m3i_pkg::*;

	localparam int E    = ELEM_WIDTH;
	localparam int PW   = 2 * E;
	localparam int CW   = 2 * E + 1;
	localparam int HW   = CW - E;
	localparam int DW   = 3 * E + 3;
	localparam int NUMA = CW + 2 * FRAC_BITS + 1;
	localparam int NW   = ((NUMA > DW) ? NUMA : DW) + 1;
	localparam int TW   = DET_MIN_WIDTH + 2 * FRAC_BITS;
	localparam int SW   = (DW > TW) ? DW : TW;

	logic adv;
	logic [DET_MIN_WIDTH-1:0] det_min_q;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			det_min_q <= DET_MIN_RESET;
		end else if (cfg_we) begin
			det_min_q <= cfg_wdata;
		end
	end

	assign in_ready = !out_valid || out_ready;
	assign adv      = in_ready;

	logic signed [E-1:0] a_in [NUM_ELEM];
	assign a_in[0] = a00;
	assign a_in[1] = a01;
	assign a_in[2] = a02;
	assign a_in[3] = a10;
	assign a_in[4] = a11;
	assign a_in[5] = a12;
	assign a_in[6] = a20;
	assign a_in[7] = a21;
	assign a_in[8] = a22;

	// Stage 1: the eighteen element products
	logic signed [PW-1:0] p_s1 [NUM_PROD];
	logic signed [E-1:0]  r0_s1 [3];
	logic                 vld_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < NUM_PROD; k++) begin
				p_s1[k] <= a_in[PA[k]] * a_in[PB[k]];
			end
			for (int k = 0; k < 3; k++) begin
				r0_s1[k] <= a_in[k];
			end
		end
	end

	// Stage 2: cofactors
	logic signed [CW-1:0] c_s2 [NUM_ELEM];
	logic signed [E-1:0]  r0_s2 [3];
	logic                 vld_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < NUM_ELEM; k++) begin
				c_s2[k] <= CW'(p_s1[2*k]) - CW'(p_s1[2*k+1]);
			end
			r0_s2 <= r0_s1;
		end
	end

	// Stage 3: determinant partial products, cofactor split into high and low halves
	logic signed [CW-1:0]  c_s3 [NUM_ELEM];
	logic signed [PW:0]    pl_s3 [3];
	logic signed [E+HW-1:0] ph_s3 [3];
	logic                  vld_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int j = 0; j < 3; j++) begin
				pl_s3[j] <= r0_s2[j] * $signed({1'b0, c_s2[DET_COF[j]][E-1:0]});
				ph_s3[j] <= r0_s2[j] * $signed(c_s2[DET_COF[j]][CW-1:E]);
			end
			c_s3 <= c_s2;
		end
	end

	// Stage 4: determinant
	logic signed [DW-1:0] det_c;
	logic signed [DW-1:0] det_s4;
	logic signed [CW-1:0] c_s4 [NUM_ELEM];
	logic                 vld_s4;

	always_comb begin
		det_c = '0;
		for (int j = 0; j < 3; j++) begin
			det_c = det_c + (DW'(ph_s3[j]) <<< E) + DW'(pl_s3[j]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			det_s4 <= det_c;
			c_s4   <= c_s3;
		end
	end

	// Stage 5: magnitudes, signs, threshold, divider operands
	logic [DW-1:0]       dabs_c;
	logic [CW-1:0]       cabs_c [NUM_ELEM];
	logic [NW-1:0]       num_s5 [NUM_ELEM];
	logic [NW-1:0]       den_s5;
	logic [NUM_ELEM-1:0] neg_s5;
	logic                sing_s5;
	logic                vld_s5;

	always_comb begin
		dabs_c = det_s4[DW-1] ? DW'(-det_s4) : DW'(det_s4);
		for (int k = 0; k < NUM_ELEM; k++) begin
			cabs_c[k] = c_s4[k][CW-1] ? CW'(-c_s4[k]) : CW'(c_s4[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < NUM_ELEM; k++) begin
				num_s5[k] <= (NW'(cabs_c[k]) << (2 * FRAC_BITS + 1)) + NW'(dabs_c);
				neg_s5[k] <= c_s4[k][CW-1] ^ det_s4[DW-1];
			end
			den_s5  <= NW'(dabs_c) << 1;
			sing_s5 <= SW'(dabs_c) <= (SW'(det_min_q) << (2 * FRAC_BITS));
		end
	end

	// Divider: index 0 holds the overflow check, index j+1 has quotient bit E-1-j resolved
	logic [NW-1:0]       rem_sd [E+1][NUM_ELEM];
	logic [E-1:0]        quo_sd [E+1][NUM_ELEM];
	logic [NW-1:0]       den_sd [E+1];
	logic [NUM_ELEM-1:0] neg_sd [E+1];
	logic [NUM_ELEM-1:0] ovf_sd [E+1];
	logic                sing_sd [E+1];
	logic                vld_sd [E+1];

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < NUM_ELEM; k++) begin
				rem_sd[0][k]    <= num_s5[k];
				quo_sd[0][k]    <= '0;
				ovf_sd[0][k]    <= (num_s5[k] >> E) >= den_s5;
			end
			den_sd[0]  <= den_s5;
			neg_sd[0]  <= neg_s5;
			sing_sd[0] <= sing_s5;
		end
	end

	for (genvar j = 0; j < E; j++) begin : g_div
		localparam int BIT = E - 1 - j;
		logic [NW-1:0] rem_n [NUM_ELEM];
		logic [E-1:0]  quo_n [NUM_ELEM];

		always_comb begin
			for (int k = 0; k < NUM_ELEM; k++) begin
				rem_n[k] = rem_sd[j][k];
				quo_n[k] = quo_sd[j][k];
				if ((rem_sd[j][k] >> BIT) >= den_sd[j]) begin
					rem_n[k] = rem_sd[j][k] - (den_sd[j] << BIT);
					quo_n[k] = quo_sd[j][k] | (E'(1) << BIT);
				end
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_sd[j+1]  <= rem_n;
				quo_sd[j+1]  <= quo_n;
				den_sd[j+1]  <= den_sd[j];
				neg_sd[j+1]  <= neg_sd[j];
				ovf_sd[j+1]  <= ovf_sd[j];
				sing_sd[j+1] <= sing_sd[j];
			end
		end
	end

	// Output stage: sign, saturation, singular override
	logic [E:0]          lim_c [NUM_ELEM];
	logic [NUM_ELEM-1:0] over_c;
	logic [E-1:0]        mag_c [NUM_ELEM];
	logic [E-1:0]        b_c [NUM_ELEM];
	logic [E-1:0]        b_q [NUM_ELEM];
	logic                sing_q;
	logic                sat_q;

	always_comb begin
		for (int k = 0; k < NUM_ELEM; k++) begin
			lim_c[k]  = ((E+1)'(1) << (E - 1)) - (E+1)'(!neg_sd[E][k]);
			over_c[k] = ovf_sd[E][k] || ({1'b0, quo_sd[E][k]} > lim_c[k]);
			mag_c[k]  = over_c[k] ? lim_c[k][E-1:0] : quo_sd[E][k];
			if (sing_sd[E]) begin
				b_c[k] = '0;
			end else begin
				b_c[k] = neg_sd[E][k] ? E'(-mag_c[k]) : mag_c[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			b_q    <= b_c;
			sing_q <= sing_sd[E];
			sat_q  <= !sing_sd[E] && (|over_c);
		end
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			vld_s5    <= 1'b0;
			out_valid <= 1'b0;
			for (int j = 0; j <= E; j++) begin
				vld_sd[j] <= 1'b0;
			end
		end else if (adv) begin
			vld_s1    <= in_valid;
			vld_s2    <= vld_s1;
			vld_s3    <= vld_s2;
			vld_s4    <= vld_s3;
			vld_s5    <= vld_s4;
			vld_sd[0] <= vld_s5;
			for (int j = 0; j < E; j++) begin
				vld_sd[j+1] <= vld_sd[j];
			end
			out_valid <= vld_sd[E];
		end
	end

	assign b00       = b_q[0];
	assign b01       = b_q[1];
	assign b02       = b_q[2];
	assign b10       = b_q[3];
	assign b11       = b_q[4];
	assign b12       = b_q[5];
	assign b20       = b_q[6];
	assign b21       = b_q[7];
	assign b22       = b_q[8];
	assign singular  = sing_q;
	assign saturated = sat_q;

	a_sing_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && singular |-> !saturated && b00 == '0 && b11 == '0 && b22 == '0)
		else $error("singular item carries nonzero data");

	a_stall_only: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input held off without an output stall");

	a_rise_adv: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_ready))
		else $error("output valid rose while pipeline was frozen");

endmodule

FILE: bench/m3i_checker.sv
// Checker for the 3x3 matrix inverse: predicts each inverse and compares it with the block's output.
module m3i_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [m3i_pkg::DET_MIN_WIDTH-1:0] cfg_wdata,
	input  logic in_valid,
	input  logic in_ready,
	input  logic signed [31:0] a [9],
	input  logic out_valid,
	input  logic out_ready,
	input  logic signed [31:0] b [9],
	input  logic singular,
	input  logic saturated,
	output int   errors,
	output int   pending,
	output int   n_singular,
	output int   n_saturated
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic signed [31:0] e [9];
		logic sing;
		logic sat;
	} inverse_t;

	inverse_t inv_q[$];
	logic [30:0] det_min_q;

	// Product index pairs for the nine cofactors, row-major.
	localparam int CA [18] = '{4, 5, 7, 8, 1, 2, 5, 3, 8, 6, 2, 0, 3, 4, 6, 7, 0, 1};
	localparam int CB [18] = '{8, 7, 2, 1, 5, 4, 6, 8, 0, 2, 3, 5, 7, 6, 1, 0, 4, 3};

	function automatic inverse_t invert(input logic signed [31:0] m [9], input logic [30:0] dmin);
		inverse_t r;
		logic signed [127:0] cof [9];
		logic signed [127:0] det;
		logic [127:0] dabs, cabs, num, q;
		logic [128:0] thr;
		logic neg;
		logic [63:0] lim;
		for (int k = 0; k < 9; k++) begin
			cof[k] = 128'(m[CA[2*k]]) * 128'(m[CB[2*k]])
				- 128'(m[CA[2*k+1]]) * 128'(m[CB[2*k+1]]);
		end
		det = 128'(m[0]) * cof[0] + 128'(m[1]) * cof[3] + 128'(m[2]) * cof[6];
		dabs = det[127] ? -det : det;
		thr = 129'(dmin) << 32;
		r.sing = 0;
		r.sat = 0;
		if (thr >= {1'b0, dabs}) begin
			foreach (r.e[k]) r.e[k] = '0;
			r.sing = 1;
			return r;
		end
		for (int k = 0; k < 9; k++) begin
			neg = cof[k][127] ^ det[127];
			cabs = cof[k][127] ? -cof[k] : cof[k];
			// round half away: (2|c|*2^32 + |d|) / (2|d|)
			num = (cabs << 33) + dabs;
			q = num / (dabs << 1);
			lim = neg ? 64'h8000_0000 : 64'h7fff_ffff;
			if (q > 128'(lim)) begin
				q = 128'(lim);
				r.sat = 1;
			end
			r.e[k] = neg ? -q[31:0] : q[31:0];
		end
		return r;
	endfunction

	assign pending = inv_q.size();

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			det_min_q <= m3i_pkg::DET_MIN_RESET;
			inv_q.delete();
			errors <= 0;
			n_singular <= 0;
			n_saturated <= 0;
		end else begin
			if (cfg_we) det_min_q <= cfg_wdata;
			if (in_valid && in_ready) inv_q.push_back(invert(a, det_min_q));
			if (out_valid && out_ready) begin
				if (inv_q.size() == 0) begin
					if (errors < 10) $display("unexpected output item at %0t", $realtime);
					errors <= errors + 1;
				end else begin
					inverse_t x;
					logic bad;
					x = inv_q.pop_front();
					bad = (x.sing !== singular) || (x.sat !== saturated);
					foreach (b[k]) if (x.e[k] !== b[k]) bad = 1;
					if (bad) begin
						if (errors < 10) begin
							$display("mismatch at %0t: sing %0b/%0b sat %0b/%0b", $realtime,
								x.sing, singular, x.sat, saturated);
							foreach (b[k]) $display("  b[%0d] exp %h got %h", k, x.e[k], b[k]);
						end
						errors <= errors + 1;
					end
					n_singular <= n_singular + x.sing;
					n_saturated <= n_saturated + x.sat;
				end
			end
		end
	end
endmodule

FILE: bench/testbench.sv
// Top of the bench: drives matrices and det_min settings into the inverse and gives the verdict.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 0, arst_n = 0;
	logic cfg_we = 0;
	logic [30:0] cfg_wdata = '0;
	logic in_valid = 0, out_ready = 0;
	logic in_ready, out_valid, singular, saturated;
	logic signed [31:0] a [9];
	logic signed [31:0] b [9];
	int errors, pending, n_singular, n_saturated;
	int cycles = 0;
	int gap_left = 0, stall_left = 0;
	logic quiet = 0;

	initial begin
		foreach (a[k]) a[k] = '0;
		forever #5 clk = ~clk;
	end

	matrix3x3_inverse uut (
		.clk, .arst_n, .cfg_we, .cfg_wdata, .in_valid, .in_ready,
		.a00(a[0]), .a01(a[1]), .a02(a[2]), .a10(a[3]), .a11(a[4]), .a12(a[5]),
		.a20(a[6]), .a21(a[7]), .a22(a[8]),
		.out_valid, .out_ready,
		.b00(b[0]), .b01(b[1]), .b02(b[2]), .b10(b[3]), .b11(b[4]), .b12(b[5]),
		.b20(b[6]), .b21(b[7]), .b22(b[8]),
		.singular, .saturated
	);

	m3i_checker chk (
		.clk, .arst_n, .cfg_we, .cfg_wdata, .in_valid, .in_ready, .a, .out_valid, .out_ready,
		.b, .singular, .saturated, .errors, .pending, .n_singular, .n_saturated
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("timeout after %0d cycles", cycles);
			$display("testbench: done, errors");
			$finish;
		end
	end

	// Receiver: stall in random bursts.
	always @(posedge clk) begin
		if (!arst_n) out_ready <= 0;
		else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 0;
		end else if (!quiet && $urandom_range(0, 7) == 0) begin
			stall_left <= $urandom_range(0, 3);
			out_ready <= 0;
		end else out_ready <= 1;
	end

	function automatic logic signed [31:0] rand_elem(input int mode);
		case (mode)
			0: return $urandom_range(0, 32'h3_0000) - 32'sh1_8000;
			1: return $signed($urandom());
			2: return $urandom_range(0, 255) - 128;
			default: return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
		endcase
	endfunction

	task automatic send(input logic signed [31:0] m [9]);
		while (gap_left > 0) begin
			@(posedge clk);
			gap_left--;
		end
		foreach (a[k]) a[k] <= m[k];
		in_valid <= 1;
		do @(posedge clk); while (!in_ready);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			in_valid <= 0;
			gap_left = $urandom_range(1, 4);
		end
	endtask

	task automatic drain();
		// a pending gap has already dropped valid at this edge
		if (in_valid && gap_left == 0) in_valid <= 0;
		while (pending != 0) @(posedge clk);
		repeat (45) @(posedge clk);
	endtask

	task automatic write_det_min(input logic [30:0] v);
		cfg_wdata <= v;
		cfg_we <= 1;
		@(posedge clk);
		cfg_we <= 0;
	endtask

	task automatic random_items(input int n);
		logic signed [31:0] m [9];
		int mode;
		for (int i = 0; i < n; i++) begin
			mode = $urandom_range(0, 9);
			foreach (m[k]) m[k] = rand_elem(mode < 5 ? 0 : mode < 8 ? 1 : mode < 9 ? 2 : 3);
			// make row 2 equal to row 0 in some items to land on singular
			if ($urandom_range(0, 9) == 0) for (int k = 0; k < 3; k++) m[6+k] = m[k];
			send(m);
		end
	endtask

	initial begin
		logic signed [31:0] m [9];
		logic signed [31:0] one;
		one = 32'sh1_0000;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// identity, scaled identity, zero, all extremes, tiny and near-singular cases
		foreach (m[k]) m[k] = (k % 4 == 0) ? one : 0;
		send(m);
		foreach (m[k]) m[k] = (k % 4 == 0) ? -2 * one : 0;
		send(m);
		foreach (m[k]) m[k] = 0;
		send(m);
		foreach (m[k]) m[k] = 32'sh7fff_ffff;
		send(m);
		foreach (m[k]) m[k] = 32'sh8000_0000;
		send(m);
		foreach (m[k]) m[k] = (k % 4 == 0) ? 32'sh8000_0000 : 32'sh7fff_ffff;
		send(m);
		foreach (m[k]) m[k] = (k % 4 == 0) ? 32'sh7fff_ffff : 0;
		send(m);
		foreach (m[k]) m[k] = (k % 4 == 0) ? 1 : 0;
		send(m);
		foreach (m[k]) m[k] = (k % 4 == 0) ? 32'sh100 : 0;
		send(m);
		foreach (m[k]) m[k] = (k % 4 == 0) ? 32'sh100 : 1;
		send(m);
		foreach (m[k]) m[k] = (k % 4 == 0) ? 3 * one : -one;
		send(m);
		foreach (m[k]) m[k] = (k % 4 == 0) ? -one : 32'sh8000_0000;
		send(m);
		foreach (m[k]) m[k] = k * one;
		send(m);
		drain();
		write_det_min('0);
		random_items(60);
		drain();
		write_det_min(31'h7fff_ffff);
		random_items(60);
		drain();
		write_det_min(31'h1_0000);
		random_items(60);
		drain();
		write_det_min(31'($urandom()));
		random_items(60);
		drain();
		write_det_min(31'd1);
		random_items(250);
		quiet = 1;
		random_items(60);
		drain();
		$display("covered %0d cycles, five det_min settings; %0d singular, %0d saturated results",
			cycles, n_singular, n_saturated);
		if (errors == 0) $display("testbench: done, clean");
		else $display("testbench: done, errors");
		$finish;
	end
endmodule
